// ===== hw/rtl/lroa_pkg.sv =====
package lroa_pkg;

  // Default geometry
  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_COORD_BITS  = 16;

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int ID_W   = 7;
  localparam int KIND_W = 2;
  localparam int OVL_W  = 17;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Match kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REGION = 2'd2;

  // Overlap threshold: Q1.16, 1.0 and reset value
  localparam logic [OVL_W-1:0] OVL_ONE   = 17'd65536;
  localparam logic [OVL_W-1:0] OVL_RESET = 17'd32768;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;      // latch request, clear result
    logic clear;       // empty the region table
    logic append;      // write region, bump count
    logic drop;        // flag dropped append
    logic bound;       // form quad bounds
    logic larea;       // form line area
    logic init;        // load best fraction with threshold
    logic scan_start;  // rewind scan index
    logic issue;       // read next region into the pipe
    logic pass2;       // region-area pass
  } lroa_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic la_zero;
    logic count_zero;
    logic issue_last;
    logic pipe_busy;
    logic found;
  } lroa_sts_t;

endpackage

// ===== hw/rtl/lroa_ram.sv =====
module lroa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/lroa_ctrl.sv =====
module lroa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lroa_pkg::REQ_W-1:0]     in_req_type,
  input  lroa_pkg::lroa_sts_t            sts,
  output lroa_pkg::lroa_cmd_t            cmd,
  output logic                           busy,
  output logic                           out_valid
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BOUND = 7'b0000010,
    S_AREA  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   phase_r, phase_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.pass2 = pass2_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_req_type)
            lroa_pkg::REQ_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_DONE;
            end
            lroa_pkg::REQ_APPEND: begin
              if (sts.full) begin
                cmd.drop = 1'b1;
              end else begin
                cmd.append = 1'b1;
              end
              state_nxt = S_DONE;
            end
            lroa_pkg::REQ_QUERY: begin
              state_nxt = S_BOUND;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_BOUND: begin
        cmd.bound = 1'b1;
        state_nxt = S_AREA;
      end
      S_AREA: begin
        cmd.larea = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // empty quad or empty table: no region
        if (sts.la_zero || sts.count_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.init       = 1'b1;
          cmd.scan_start = 1'b1;
          pass2_nxt      = 1'b0;
          phase_nxt      = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // regions are issued with an idle phase between them so the running best is settled
        if (!phase_r) begin
          cmd.issue = 1'b1;
          if (sts.issue_last) begin
            state_nxt = S_DRAIN;
          end else begin
            phase_nxt = 1'b1;
          end
        end else begin
          phase_nxt = 1'b0;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          if (!pass2_r && !sts.found) begin
            // fall back to region-area fractions
            pass2_nxt      = 1'b1;
            cmd.init       = 1'b1;
            cmd.scan_start = 1'b1;
            phase_nxt      = 1'b0;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass2_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== hw/rtl/lroa_dp.sv =====
module lroa_dp #(
  parameter int MAX_REGIONS = lroa_pkg::DEF_MAX_REGIONS,
  parameter int COORD_BITS  = lroa_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lroa_pkg::lroa_cmd_t               cmd,
  output lroa_pkg::lroa_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [lroa_pkg::OVL_W-1:0]        cfg_ovl_thresh,
  input  logic signed [COORD_BITS-1:0]      in_x0,
  input  logic signed [COORD_BITS-1:0]      in_y0,
  input  logic signed [COORD_BITS-1:0]      in_x1,
  input  logic signed [COORD_BITS-1:0]      in_y1,
  input  logic signed [COORD_BITS-1:0]      in_x2,
  input  logic signed [COORD_BITS-1:0]      in_y2,
  input  logic signed [COORD_BITS-1:0]      in_x3,
  input  logic signed [COORD_BITS-1:0]      in_y3,
  output logic signed [lroa_pkg::ID_W-1:0]  out_rgn_idx,
  output logic [lroa_pkg::KIND_W-1:0]       out_match_kind,
  output logic                              out_table_full
);

  localparam int C   = COORD_BITS;
  localparam int AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW  = $clog2(MAX_REGIONS + 1);
  localparam int RW  = 4 * C + 2;                       // left, top, right, bottom
  localparam int AR  = 2 * C;                           // area width
  localparam int NW  = (AR > lroa_pkg::OVL_W) ? AR : lroa_pkg::OVL_W;
  localparam int EW  = (CW > lroa_pkg::ID_W) ? CW : lroa_pkg::ID_W;

  // Threshold register
  logic [lroa_pkg::OVL_W-1:0] ovl_thresh_r;

  // Table fill
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  // Latched corners and bounds
  logic signed [C-1:0] cx_r [4];
  logic signed [C-1:0] cy_r [4];
  logic signed [C-1:0] qx1_r, qy1_r, qx2_r, qy2_r;
  logic signed [C-1:0] qx1_nxt, qy1_nxt, qx2_nxt, qy2_nxt;
  logic [AR-1:0]       la_r;
  logic [C-1:0]        lsx, lsy;
  logic signed [C:0]   ldx, ldy;

  // Region RAM
  logic [RW-1:0] wdata, rdata;
  logic signed [C:0] app_right, app_bottom;

  // Scan pipe
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0] id1_r, id2_r, id3_r, id4_r;
  logic [C-1:0]  isx_r, isy_r, rw_r, rh_r;
  logic [C-1:0]  isx_nxt, isy_nxt, rw_nxt, rh_nxt;
  logic [AR-1:0] inter_r, ra_r;
  logic [NW-1:0] inter4_r, den4_r, den3;
  logic          skip4_r;
  logic [2*NW-1:0] lhs_r, rhs_r, lhs_nxt, rhs_nxt;

  // Running best and result
  logic [NW-1:0]                   bn_r, bd_r;
  logic signed [lroa_pkg::ID_W-1:0] id_r;
  logic [lroa_pkg::KIND_W-1:0]     kind_r;
  logic                            full_r;
  logic                            better;
  logic [EW-1:0]                   id_ext;

  // Region fields from RAM
  logic signed [C-1:0] rd_l, rd_t;
  logic signed [C:0]   rd_right, rd_b;
  logic signed [C+1:0] lo_x, hi_x, lo_y, hi_y, dix, diy, drw, drh;

  // ---------------- table control ----------------
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.scan_start) begin
      idx_nxt = '0;
    end else if (cmd.issue) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ovl_thresh_r <= lroa_pkg::OVL_RESET;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        ovl_thresh_r <= cfg_ovl_thresh;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Append entry: right and bottom formed once at write time
  assign app_right  = (C+1)'(in_x0) + (C+1)'(in_x1);
  assign app_bottom = (C+1)'(in_y0) + (C+1)'(in_y1);
  assign wdata      = {in_x0, in_y0, app_right, app_bottom};

  lroa_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count_r[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // ---------------- query setup ----------------
  always_comb begin
    qx1_nxt = cx_r[0];
    qx2_nxt = cx_r[0];
    qy1_nxt = cy_r[0];
    qy2_nxt = cy_r[0];
    for (int k = 1; k < 4; k++) begin
      if (cx_r[k] < qx1_nxt) qx1_nxt = cx_r[k];
      if (cx_r[k] > qx2_nxt) qx2_nxt = cx_r[k];
      if (cy_r[k] < qy1_nxt) qy1_nxt = cy_r[k];
      if (cy_r[k] > qy2_nxt) qy2_nxt = cy_r[k];
    end
  end

  // bounds are ordered, so the extents never go negative
  assign ldx = (C+1)'(qx2_r) - (C+1)'(qx1_r);
  assign ldy = (C+1)'(qy2_r) - (C+1)'(qy1_r);
  assign lsx = ldx[C-1:0];
  assign lsy = ldy[C-1:0];

  // ---------------- scan stage 1: extents ----------------
  assign rd_l     = rdata[RW-1 -: C];
  assign rd_t     = rdata[RW-C-1 -: C];
  assign rd_right = rdata[2*C+1 -: C+1];
  assign rd_b     = rdata[C:0];

  always_comb begin
    lo_x = ((C+2)'(qx1_r) > (C+2)'(rd_l)) ? (C+2)'(qx1_r) : (C+2)'(rd_l);
    hi_x = ((C+2)'(qx2_r) < (C+2)'(rd_right)) ? (C+2)'(qx2_r) : (C+2)'(rd_right);
    lo_y = ((C+2)'(qy1_r) > (C+2)'(rd_t)) ? (C+2)'(qy1_r) : (C+2)'(rd_t);
    hi_y = ((C+2)'(qy2_r) < (C+2)'(rd_b)) ? (C+2)'(qy2_r) : (C+2)'(rd_b);
    dix  = hi_x - lo_x;
    diy  = hi_y - lo_y;
    drw  = (C+2)'(rd_right) - (C+2)'(rd_l);
    drh  = (C+2)'(rd_b) - (C+2)'(rd_t);
    isx_nxt = (dix > 0) ? dix[C-1:0] : '0;
    isy_nxt = (diy > 0) ? diy[C-1:0] : '0;
    rw_nxt  = (drw > 0) ? drw[C-1:0] : '0;
    rh_nxt  = (drh > 0) ? drh[C-1:0] : '0;
  end

  // ---------------- stage 3: cross products ----------------
  assign den3    = cmd.pass2 ? NW'(ra_r) : NW'(la_r);
  assign lhs_nxt = NW'(inter_r) * bd_r;
  assign rhs_nxt = bn_r * den3;

  // ---------------- stage 4: compare ----------------
  assign better = v4_r && !skip4_r && (lhs_r > rhs_r);
  assign id_ext = EW'(id4_r);

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      cx_r[0] <= in_x0;
      cy_r[0] <= in_y0;
      cx_r[1] <= in_x1;
      cy_r[1] <= in_y1;
      cx_r[2] <= in_x2;
      cy_r[2] <= in_y2;
      cx_r[3] <= in_x3;
      cy_r[3] <= in_y3;
    end
    if (cmd.bound) begin
      qx1_r <= qx1_nxt;
      qy1_r <= qy1_nxt;
      qx2_r <= qx2_nxt;
      qy2_r <= qy2_nxt;
    end
    if (cmd.larea) begin
      la_r <= AR'(lsx * lsy);
    end

    // pipe payload
    id1_r    <= idx_r;
    id2_r    <= id1_r;
    isx_r    <= isx_nxt;
    isy_r    <= isy_nxt;
    rw_r     <= rw_nxt;
    rh_r     <= rh_nxt;
    id3_r    <= id2_r;
    inter_r  <= AR'(isx_r * isy_r);
    ra_r     <= AR'(rw_r * rh_r);
    id4_r    <= id3_r;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    inter4_r <= NW'(inter_r);
    den4_r   <= den3;
    skip4_r  <= cmd.pass2 && (ra_r == '0);

    // running best
    if (cmd.init) begin
      bn_r <= NW'(ovl_thresh_r);
      bd_r <= NW'(lroa_pkg::OVL_ONE);
    end else if (better) begin
      bn_r <= inter4_r;
      bd_r <= den4_r;
    end

    // result
    if (cmd.accept) begin
      id_r   <= '1;
      kind_r <= lroa_pkg::KIND_NONE;
    end else if (better) begin
      id_r   <= $signed(id_ext[lroa_pkg::ID_W-1:0]);
      kind_r <= cmd.pass2 ? lroa_pkg::KIND_REGION : lroa_pkg::KIND_LINE;
    end
    if (cmd.drop) begin
      full_r <= 1'b1;
    end else if (cmd.accept) begin
      full_r <= 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.full       = (count_r == CW'(MAX_REGIONS));
    sts.la_zero    = (la_r == '0);
    sts.count_zero = (count_r == '0);
    sts.issue_last = ((idx_r + CW'(1)) == count_r);
    sts.pipe_busy  = v1_r || v2_r || v3_r || v4_r;
    sts.found      = (kind_r != lroa_pkg::KIND_NONE);
  end

  assign out_rgn_idx    = id_r;
  assign out_match_kind = kind_r;
  assign out_table_full = full_r;

endmodule

// ===== hw/rtl/line_region_overlap_assign.sv =====
// Line-to-region assignment. Regions are appended with start/req_type=1
// (left, top, width, height on x0..y1); req_type=0 empties the table and
// req_type=2 asks which region the quad on x0..y3 falls in. A request is
// taken when start is high and busy is low; busy stays high until the
// single result has been shown. The result sits on the out_ ports for one
// cycle with out_valid high and cannot be held off by the receiver, so it
// must be captured in that cycle. Clear and append go straight to the
// result state. A query passes the bound, area and check states, then one
// or two scan passes over the N stored regions (the second only when no
// region matched on line area; none if the quad or table is empty), then
// the result state. The scan is paced by the cross-multiply compare with
// the running best, so regions are read with an idle phase between. The
// overlap threshold is written through cfg_valid/cfg_ready, which is
// always ready; write it only while busy is low.
module line_region_overlap_assign #(
  parameter int MAX_REGIONS = lroa_pkg::DEF_MAX_REGIONS,
  parameter int COORD_BITS  = lroa_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lroa_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [COORD_BITS-1:0]      in_x0,
  input  logic signed [COORD_BITS-1:0]      in_y0,
  input  logic signed [COORD_BITS-1:0]      in_x1,
  input  logic signed [COORD_BITS-1:0]      in_y1,
  input  logic signed [COORD_BITS-1:0]      in_x2,
  input  logic signed [COORD_BITS-1:0]      in_y2,
  input  logic signed [COORD_BITS-1:0]      in_x3,
  input  logic signed [COORD_BITS-1:0]      in_y3,
  output logic                              out_valid,
  output logic signed [lroa_pkg::ID_W-1:0]  out_rgn_idx,
  output logic [lroa_pkg::KIND_W-1:0]       out_match_kind,
  output logic                              out_table_full,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lroa_pkg::OVL_W-1:0]        cfg_ovl_thresh
);

  lroa_pkg::lroa_cmd_t cmd;
  lroa_pkg::lroa_sts_t sts;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  lroa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  lroa_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_ovl_thresh  (cfg_ovl_thresh),
    .in_x0           (in_x0),
    .in_y0           (in_y0),
    .in_x1           (in_x1),
    .in_y1           (in_y1),
    .in_x2           (in_x2),
    .in_y2           (in_y2),
    .in_x3           (in_x3),
    .in_y3           (in_y3),
    .out_rgn_idx     (out_rgn_idx),
    .out_match_kind  (out_match_kind),
    .out_table_full  (out_table_full)
  );

endmodule
